// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define AST_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed while running");

// Clocked check that also holds through reset.
`define AST_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("check failed around reset");

`endif

// ===== rtl/core/utf8tc_pkg.sv =====
// Shared types, constants and the UTF-8 encoder function of the transcoder.
package utf8tc_pkg;

  localparam int unsigned GRP_MAX = 5;
  localparam int unsigned GRP_CNT_W = $clog2(GRP_MAX + 1);

  localparam logic [7:0] BOM16_B0 = 8'hFF;
  localparam logic [7:0] BOM16_B1 = 8'hFE;
  localparam logic [7:0] BOM8_B0  = 8'hEF;
  localparam logic [7:0] BOM8_B1  = 8'hBB;
  localparam logic [7:0] BOM8_B2  = 8'hBF;
  localparam logic [7:0] QMARK    = 8'h3F;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } cp_enc_t;

  // One input beat's worth of output bytes, first byte in slot 0.
  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] bytes;
    logic [GRP_CNT_W-1:0]    cnt;
    logic                    term;
  } grp_t;

  function automatic cp_enc_t enc_cp(input logic [20:0] cp);
    cp_enc_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.bytes[0] = cp[7:0];
      e.n = 3'd1;
    end else if (cp <= 21'h7FF) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.n = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.n = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.n = 3'd4;
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/utf8tc_decode.sv =====
// Input register, stream-mode tracking and per-beat output group builder.
module utf8tc_decode
  import utf8tc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       grp_free,
  output logic       grp_load,
  output grp_t       grp
);

  typedef enum logic [1:0] {MODE_DETECT, MODE_UTF16, MODE_PASS} mode_t;

  logic       inr_valid_r;
  logic [7:0] inr_byte_r;
  logic       inr_last_r;

  mode_t      mode_r, mode_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic [7:0] held2_r, held2_nxt;
  logic [7:0] low_r, low_nxt;
  logic       half_r, half_nxt;
  logic [9:0] ph_r, ph_nxt;
  logic       pv_r, pv_nxt;
  logic       stop_r, stop_nxt;

  logic [2:0][7:0]      pre;
  logic [1:0]           pre_n;
  logic [20:0]          cp;
  logic                 cp_on;
  logic                 raw_on;
  logic [15:0]          unit;
  cp_enc_t              enc;
  cp_enc_t              raw_enc;
  logic [GRP_CNT_W-1:0] pos;
  logic                 consume;

  assign unit = {inr_byte_r, low_r};

  always_comb begin
    mode_nxt  = mode_r;
    seen_nxt  = seen_r;
    held1_nxt = held1_r;
    held2_nxt = held2_r;
    low_nxt   = low_r;
    half_nxt  = half_r;
    ph_nxt    = ph_r;
    pv_nxt    = pv_r;
    stop_nxt  = stop_r;
    pre       = '0;
    pre_n     = 2'd0;
    cp        = '0;
    cp_on     = 1'b0;

    unique case (mode_r)
      MODE_DETECT: begin
        if (seen_r == 2'd0) begin
          if (inr_last_r) begin
            pre[0] = inr_byte_r;
            pre_n  = 2'd1;
          end else begin
            held1_nxt = inr_byte_r;
            seen_nxt  = 2'd1;
          end
        end else if (seen_r == 2'd1) begin
          if (held1_r == BOM16_B0 && inr_byte_r == BOM16_B1) begin
            mode_nxt = MODE_UTF16;
          end else if (held1_r == BOM8_B0 && inr_byte_r == BOM8_B1) begin
            held2_nxt = inr_byte_r;
            seen_nxt  = 2'd2;
            if (inr_last_r) begin
              pre[0] = held1_r;
              pre[1] = inr_byte_r;
              pre_n  = 2'd2;
            end
          end else begin
            pre[0]   = held1_r;
            pre[1]   = inr_byte_r;
            pre_n    = 2'd2;
            mode_nxt = MODE_PASS;
          end
        end else begin
          // Full UTF-8 mark is dropped; a near miss replays the held bytes.
          if (inr_byte_r != BOM8_B2) begin
            pre[0] = held1_r;
            pre[1] = held2_r;
            pre[2] = inr_byte_r;
            pre_n  = 2'd3;
          end
          mode_nxt = MODE_PASS;
        end
      end
      MODE_UTF16: begin
        if (half_r) begin
          half_nxt = 1'b0;
          if (!stop_r) begin
            if (pv_r && unit >= SURR_LO_MIN && unit <= SURR_LO_MAX) begin
              cp     = SUPP_BASE + {1'b0, ph_r, unit[9:0]};
              cp_on  = 1'b1;
              pv_nxt = 1'b0;
            end else begin
              // A pending high surrogate here is a broken pair: emit '?'; then handle this unit on its own.
              if (pv_r) begin
                pre[0] = QMARK;
                pre_n  = 2'd1;
                pv_nxt = 1'b0;
              end
              if (unit == 16'h0000) begin
                stop_nxt = 1'b1;
              end else if (unit >= SURR_HI_MIN && unit <= SURR_HI_MAX) begin
                ph_nxt = unit[9:0];
                pv_nxt = 1'b1;
              end else begin
                cp    = {5'b0, unit};
                cp_on = 1'b1;
              end
            end
          end
        end else begin
          low_nxt  = inr_byte_r;
          half_nxt = 1'b1;
        end
      end
      default: begin
        pre[0] = inr_byte_r;
        pre_n  = 2'd1;
      end
    endcase

    // A high surrogate still waiting at end of file goes out raw.
    raw_on  = inr_last_r && mode_nxt == MODE_UTF16 && pv_nxt && !stop_nxt;
    enc     = enc_cp(cp);
    raw_enc = enc_cp({5'b0, 6'b110110, ph_nxt});

    pos       = '0;
    grp.bytes = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < pre_n) begin
        grp.bytes[pos] = pre[k];
        pos = pos + 1'b1;
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (cp_on && 3'(k) < enc.n) begin
        grp.bytes[pos] = enc.bytes[k];
        pos = pos + 1'b1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (raw_on) begin
        grp.bytes[pos] = raw_enc.bytes[k];
        pos = pos + 1'b1;
      end
    end
    if (inr_last_r) begin
      grp.bytes[pos] = TERM_BYTE;
      pos = pos + 1'b1;
    end
    grp.cnt  = pos;
    grp.term = inr_last_r;

    // End of file: start over for the next one.
    if (inr_last_r) begin
      mode_nxt = MODE_DETECT;
      seen_nxt = 2'd0;
      half_nxt = 1'b0;
      pv_nxt   = 1'b0;
      stop_nxt = 1'b0;
    end
  end

  // Beats that produce nothing retire without waiting for the output side.
  assign consume   = inr_valid_r && (grp.cnt == '0 || grp_free);
  assign grp_load  = inr_valid_r && grp.cnt != '0 && grp_free;
  assign in_tready = !inr_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_valid_r <= 1'b0;
      mode_r      <= MODE_DETECT;
      seen_r      <= 2'd0;
      held1_r     <= '0;
      held2_r     <= '0;
      low_r       <= '0;
      half_r      <= 1'b0;
      ph_r        <= '0;
      pv_r        <= 1'b0;
      stop_r      <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        inr_valid_r <= 1'b1;
        inr_byte_r  <= in_tdata;
        inr_last_r  <= in_tlast;
      end else if (consume) begin
        inr_valid_r <= 1'b0;
      end
      if (consume) begin
        mode_r  <= mode_nxt;
        seen_r  <= seen_nxt;
        held1_r <= held1_nxt;
        held2_r <= held2_nxt;
        low_r   <= low_nxt;
        half_r  <= half_nxt;
        ph_r    <= ph_nxt;
        pv_r    <= pv_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/utf8tc_serial.sv =====
// Result register holding one output group, drained one byte per beat.
module utf8tc_serial
  import utf8tc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       grp_load,
  input  grp_t       grp,
  output logic       grp_free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  grp_t                 grp_r;
  logic                 valid_r;
  logic [GRP_CNT_W-1:0] idx_r;
  logic                 last_beat;

  assign last_beat  = idx_r == grp_r.cnt - 1'b1;
  assign grp_free   = !valid_r || (out_tready && last_beat);
  assign out_tvalid = valid_r;
  assign out_tdata  = grp_r.bytes[idx_r];
  assign out_tlast  = grp_r.term && last_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (grp_load) begin
      grp_r   <= grp;
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (valid_r && out_tready) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/utf16le_bom_to_utf8_transcoder.sv =====
// Top level of the UTF-16LE-with-mark to UTF-8 byte stream transcoder.
//
// Input channel (in_*): one file byte per beat, in_tlast on the file's final
// byte. A file opening with FF FE is read as UTF-16LE and re-encoded as UTF-8;
// any other file passes through with a leading EF BB BF mark dropped. Each file
// ends on the output with a single 0x00 beat carrying out_tlast.
// Output channel (out_*): one UTF-8 byte per beat.
// Path: an accepted beat lands in the input register, and its output group
// (zero to five bytes) is loaded from there into the result register once that
// register is free; the result register drives out_*.
// Throughput: one input beat per cycle while each beat yields at most one byte
// and out_tready stays high. The output port moves one byte per cycle while
// out_tready is high, so while a larger group drains the next beat waits in the
// input register. Beats that yield nothing never wait on the output side.
// Reset (rst_n low, synchronous): both registers empty, stream detection
// starts over. A stalled receiver holds the current byte steady; the input
// register then fills and in_tready drops until the group drains.
module utf16le_bom_to_utf8_transcoder
  import utf8tc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // out_last
);

  grp_t grp;
  logic grp_load;
  logic grp_free;

  // Decode the registered beat into its output group.
  utf8tc_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .grp_free  (grp_free),
    .grp_load  (grp_load),
    .grp       (grp)
  );

  // Drain the group one byte per beat.
  utf8tc_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_load   (grp_load),
    .grp        (grp),
    .grp_free   (grp_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/utf8tc_checker.sv =====
// Port-level checker for the transcoder, bound to the top level.
`include "assert_macros.svh"

module utf8tc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  `AST_RUN(a_in_hold, in_tvalid && !in_tready |=> $stable({in_tvalid, in_tdata, in_tlast}))
  `AST_RUN(a_out_hold, out_tvalid && !out_tready |=> $stable({out_tvalid, out_tdata, out_tlast}))
  `AST_RUN(a_term_zero, out_tvalid && out_tlast |-> out_tdata == 8'h00)
  `AST_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid && in_tready)

endmodule

bind utf16le_bom_to_utf8_transcoder utf8tc_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/transcode_check.sv =====
`timescale 1ns / 1ps
// Channel monitor for the transcoder: predicts the UTF-8 byte stream and compares it.
module transcode_check
  import utf8tc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending_count,
  output int         beats_checked
);

  typedef enum logic [1:0] {SCAN_BOM, UTF16_TEXT, PASS_THROUGH} stream_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  utf8_beat_t   utf8_expected[$];

  stream_mode_t mode;
  logic [1:0]   seen;
  logic [7:0]   held_first;
  logic [7:0]   held_second;
  logic [7:0]   low_byte;
  logic         half_valid;
  logic [9:0]   high_bits;
  logic         high_waiting;
  logic         halted;
  int           beat_results;

  initial begin
    fail_count = 0;
    pending_count = 0;
    beats_checked = 0;
  end

  task automatic clear_stream_state();
    mode = SCAN_BOM;
    seen = 2'd0;
    held_first = 8'h00;
    held_second = 8'h00;
    low_byte = 8'h00;
    half_valid = 1'b0;
    high_bits = 10'd0;
    high_waiting = 1'b0;
    halted = 1'b0;
  endtask

  // One input beat never yields more than a group's worth of bytes.
  task automatic emit(input logic [7:0] b, input logic l);
    if (beat_results < GRP_MAX) begin
      utf8_expected.push_back({b, l});
      beat_results++;
    end
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit(cp[7:0], 1'b0);
    end else if (cp <= 21'h7FF) begin
      emit({3'b110, cp[10:6]}, 1'b0);
      emit({2'b10, cp[5:0]}, 1'b0);
    end else if (cp <= 21'hFFFF) begin
      emit({4'b1110, cp[15:12]}, 1'b0);
      emit({2'b10, cp[11:6]}, 1'b0);
      emit({2'b10, cp[5:0]}, 1'b0);
    end else begin
      emit({5'b11110, cp[20:18]}, 1'b0);
      emit({2'b10, cp[17:12]}, 1'b0);
      emit({2'b10, cp[11:6]}, 1'b0);
      emit({2'b10, cp[5:0]}, 1'b0);
    end
  endtask

  task automatic take_unit(input logic [15:0] u);
    logic joined;
    joined = 1'b0;
    if (!halted) begin
      if (high_waiting) begin
        if (u >= SURR_LO_MIN && u <= SURR_LO_MAX) begin
          // Join the pair: the low unit's bottom ten bits complete the code point.
          emit_code_point(SUPP_BASE + {1'b0, high_bits, u[9:0]});
          joined = 1'b1;
        end else begin
          emit(QMARK, 1'b0);
        end
        high_waiting = 1'b0;
        high_bits = 10'd0;
      end
      if (!joined) begin
        if (u == 16'h0000) begin
          halted = 1'b1;
        end else if (u >= SURR_HI_MIN && u <= SURR_HI_MAX) begin
          high_bits = u[9:0];
          high_waiting = 1'b1;
        end else begin
          emit_code_point({5'b0, u});
        end
      end
    end
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic l);
    beat_results = 0;
    case (mode)
      SCAN_BOM: begin
        if (seen == 2'd0) begin
          if (l) begin
            emit(b, 1'b0);
          end else begin
            held_first = b;
            seen = 2'd1;
          end
        end else if (seen == 2'd1) begin
          if (held_first == BOM16_B0 && b == BOM16_B1) begin
            mode = UTF16_TEXT;
          end else if (held_first == BOM8_B0 && b == BOM8_B1) begin
            held_second = b;
            seen = 2'd2;
            if (l) begin
              emit(held_first, 1'b0);
              emit(held_second, 1'b0);
            end
          end else begin
            emit(held_first, 1'b0);
            emit(b, 1'b0);
            mode = PASS_THROUGH;
          end
        end else begin
          // Third byte decides between a UTF-8 mark and plain data.
          if (b != BOM8_B2) begin
            emit(held_first, 1'b0);
            emit(held_second, 1'b0);
            emit(b, 1'b0);
          end
          mode = PASS_THROUGH;
        end
      end
      UTF16_TEXT: begin
        if (half_valid) begin
          half_valid = 1'b0;
          take_unit({b, low_byte});
        end else begin
          low_byte = b;
          half_valid = 1'b1;
        end
      end
      default: emit(b, 1'b0);
    endcase
    if (l) begin
      // A high surrogate still waiting at end of file goes out raw.
      if (mode == UTF16_TEXT && high_waiting && !halted)
        emit_code_point({5'b0, 6'b110110, high_bits});
      emit(TERM_BYTE, 1'b1);
      clear_stream_state();
    end
  endtask

  task automatic check_beat();
    utf8_beat_t want;
    if (utf8_expected.size() == 0) begin
      $error("out beat with nothing expected: out_byte %02h out_last %b",
             out_tdata, out_tlast);
      fail_count++;
    end else begin
      want = utf8_expected.pop_front();
      if (out_tdata !== want.data) begin
        $error("out_byte mismatch: expected %02h actual %02h", want.data, out_tdata);
        fail_count++;
      end
      if (out_tlast !== want.last) begin
        $error("out_last mismatch: expected %b actual %b", want.last, out_tlast);
        fail_count++;
      end
      beats_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stream_state();
      utf8_expected.delete();
    end else begin
      if (out_tvalid && out_tready)
        check_beat();
      if (in_tvalid && in_tready)
        predict_beat(in_tdata, in_tlast);
    end
    pending_count = utf8_expected.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: feeds byte files to the transcoder, throttles both sides, reports the verdict.
module tb_top;
  import utf8tc_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int         fail_count;
  int         pending_count;
  int         beats_checked;

  // Set for a stretch of files: neither side idles while it is high.
  logic       quiet = 1'b0;

  logic [7:0] file_bytes[$];
  int         items_sent = 0;
  int         files_sent = 0;
  int         file_idx = 0;

  always #10 clk = ~clk;

  utf16le_bom_to_utf8_transcoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  transcode_check u_transcode_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .beats_checked(beats_checked)
  );

  // Receiver: stall at random about 18 percent of the time, except in the quiet stretch.
  always @(negedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 18);
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL utf16le_bom_to_utf8_transcoder");
    $finish;
  end

  // Enter and leave at a falling edge; hold the beat until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!quiet && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Send the staged file, flag its final byte as last, then clear the stage.
  task automatic send_file();
    int i;
    for (i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    items_sent += file_bytes.size();
    files_sent++;
    file_bytes.delete();
  endtask

  task automatic add_unit(input logic [15:0] u);
    file_bytes.push_back(u[7:0]);
    file_bytes.push_back(u[15:8]);
  endtask

  task automatic add_random_unit();
    int          r;
    logic [15:0] u;
    r = $urandom_range(99);
    if (r < 22) begin
      add_unit(16'($urandom_range(16'h7F, 1)));
    end else if (r < 36) begin
      add_unit(16'($urandom_range(16'h7FF, 16'h80)));
    end else if (r < 52) begin
      u = 16'($urandom_range(16'hFFFF, 16'h800));
      // Keep this branch clear of the surrogate range.
      if (u >= SURR_HI_MIN && u <= SURR_LO_MAX)
        u = u ^ 16'h4000;
      add_unit(u);
    end else if (r < 72) begin
      add_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
      add_unit(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)));
    end else if (r < 80) begin
      // Broken pair: high surrogate followed by anything but a low one.
      add_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
      case ($urandom_range(2))
        0: add_unit(16'($urandom_range(16'h7F, 1)));
        1: add_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
        default: add_unit(16'($urandom_range(16'hFFFF, 16'hE000)));
      endcase
    end else if (r < 87) begin
      add_unit(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)));
    end else if (r < 91) begin
      add_unit($urandom_range(1) ? 16'hFFFF : 16'hE000);
    end else if (r < 97) begin
      add_unit({8'($urandom), 8'($urandom)});
    end else begin
      add_unit(16'h0000);
    end
  endtask

  task automatic build_random_file();
    int r;
    int n;
    int i;
    r = $urandom_range(99);
    if (r < 60) begin
      file_bytes.push_back(BOM16_B0);
      file_bytes.push_back(BOM16_B1);
      n = $urandom_range(8, 1);
      for (i = 0; i < n; i++)
        add_random_unit();
      case ($urandom_range(9))
        0, 1: file_bytes.push_back(8'($urandom));
        2: add_unit(16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN)));
        default: ;
      endcase
    end else if (r < 72) begin
      file_bytes.push_back(BOM8_B0);
      file_bytes.push_back(BOM8_B1);
      file_bytes.push_back(BOM8_B2);
      n = $urandom_range(8);
      for (i = 0; i < n; i++)
        file_bytes.push_back(8'($urandom));
    end else if (r < 80) begin
      // Near miss on either mark.
      if ($urandom_range(1)) begin
        file_bytes.push_back(BOM8_B0);
        file_bytes.push_back(BOM8_B1);
      end else begin
        file_bytes.push_back(BOM16_B0);
      end
      n = $urandom_range(5, 1);
      for (i = 0; i < n; i++)
        file_bytes.push_back(8'($urandom));
    end else if (r < 92) begin
      n = $urandom_range(10, 1);
      for (i = 0; i < n; i++)
        file_bytes.push_back(8'($urandom));
    end else begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(5))
          0: file_bytes.push_back(BOM16_B0);
          1: file_bytes.push_back(BOM16_B1);
          2: file_bytes.push_back(BOM8_B0);
          3: file_bytes.push_back(BOM8_B1);
          4: file_bytes.push_back(BOM8_B2);
          default: file_bytes.push_back(8'($urandom));
        endcase
      end
    end
  endtask

  // Drop the last beat off the bus, then wait until every result is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // One-byte file passes through.
    file_bytes = '{8'h41};
    send_file();
    // Bare UTF-16 mark and bare UTF-8 mark give only the terminator.
    file_bytes = '{8'hFF, 8'hFE};
    send_file();
    file_bytes = '{8'hEF, 8'hBB, 8'hBF};
    send_file();
    // Two-byte file that is not the UTF-16 mark passes through.
    file_bytes = '{8'h00, 8'hFF};
    send_file();
    // Supplementary pair, broken pair, lone low, high surrogate left at end.
    file_bytes = '{8'hFF, 8'hFE, 8'h3D, 8'hD8, 8'h00, 8'hDE, 8'h3D, 8'hD8,
                   8'h41, 8'h00, 8'h00, 8'hDC, 8'h3D, 8'hD8};
    send_file();
    // Zero unit halts output; the rest of the file is ignored.
    file_bytes = '{8'hFF, 8'hFE, 8'h00, 8'h00, 8'h7F};
    send_file();

    // Hold off until the block has emptied.
    drain();

    while (items_sent < 370) begin
      file_idx++;
      quiet <= (file_idx >= 12 && file_idx < 24);
      if (file_idx == 30)
        drain();
      build_random_file();
      send_file();
    end
    quiet <= 1'b0;

    drain();
    repeat (20) @(negedge clk);

    $display("Sent %0d files (%0d bytes): UTF-16 text with pairs and stray surrogates,",
             files_sent, items_sent);
    $display("UTF-8 marks, near misses and short files; %0d output bytes compared.",
             beats_checked);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS utf16le_bom_to_utf8_transcoder");
    end else begin
      $display("FAIL utf16le_bom_to_utf8_transcoder");
    end
    $finish;
  end

endmodule

// ===== utf16le_bom_to_utf8_transcoder.f =====
+incdir+rtl/core
rtl/core/utf8tc_pkg.sv
rtl/core/utf8tc_decode.sv
rtl/core/utf8tc_serial.sv
rtl/core/utf16le_bom_to_utf8_transcoder.sv
rtl/core/utf8tc_checker.sv
tb/transcode_check.sv
tb/tb_top.sv
